// ===== hdl/jfmp_pkg.sv =====
// ----------------------------------------------------------------------------
// jfmp_pkg
// Shared types and constants of the fuse map parser: store geometry, command
// and status codes, parser phases and character codes.
// ----------------------------------------------------------------------------
package jfmp_pkg;

    localparam int unsigned MAX_FUSES   = 524288;
    localparam int unsigned WORD_BITS   = 64;
    localparam int unsigned BIT_W       = $clog2(WORD_BITS);
    localparam int unsigned STORE_WORDS = (MAX_FUSES + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned WORD_AW     = $clog2(STORE_WORDS);
    localparam int unsigned NUM_W       = 23;
    localparam logic [NUM_W-1:0] NUM_SAT = {NUM_W{1'b1}};
    localparam int unsigned ALIGN_W     = 7;   // counts are multiples of 128

    typedef enum logic [1:0] {
        CMD_TEXT  = 2'd0,
        CMD_END   = 2'd1,
        CMD_FETCH = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_QF_BAD    = 3'd1;
    localparam logic [2:0] ST_UNALIGNED = 3'd2;
    localparam logic [2:0] ST_ADDR_OOR  = 3'd3;
    localparam logic [2:0] ST_TOO_BIG   = 3'd4;

    typedef enum logic [7:0] {
        PH_SEEK    = 8'b0000_0001,
        PH_QF_WS   = 8'b0000_0010,
        PH_QF_NUM  = 8'b0000_0100,
        PH_BODY    = 8'b0000_1000,
        PH_L_START = 8'b0001_0000,
        PH_L_NUM   = 8'b0010_0000,
        PH_L_WS    = 8'b0100_0000,
        PH_L_BITS  = 8'b1000_0000
    } phase_t;

    localparam logic [7:0] CH_Q     = 8'h51;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

endpackage

// ===== hdl/jedec_fuse_map_parser_unit.sv =====
// ----------------------------------------------------------------------------
// jedec_fuse_map_parser_unit
// Parses a JEDEC fuse file one character per item into a 8192 x 64 bit store.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item enters stage 1, where the store read returns, then
//   the output queue; one item per cycle sustained while the queue has room,
//   set by the single read-modify-write of the fuse store, with forwarding
//   between back-to-back writes.
// Reset: aresetn (synchronous, active low) clears the parser state and starts
//   a clearing pass over all 8192 store words; s_ready stays low until it
//   ends.
module jedec_fuse_map_parser_unit
    import jfmp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_command,
    input  logic [7:0]           s_text_char,
    input  logic [WORD_AW-1:0]   s_word_index,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_status,
    output logic [16:0]          m_image_bytes,
    output logic [WORD_BITS-1:0] m_fuse_word
);

    localparam int unsigned QD = 3;    // output queue depth

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    phase_t           phase_reg, phase_next;
    logic             last_q_reg, last_q_next;
    logic             seen_reg, seen_next;
    logic [NUM_W-1:0] count_reg, count_next;
    logic [NUM_W-1:0] addr_reg, addr_next;
    logic [2:0]       err_reg, err_next;

    logic             set_en;
    logic [NUM_W-1:0] set_addr;

    // ------------------------------------------------------------------
    // Store clearing pass after reset
    // ------------------------------------------------------------------
    logic               clearing_reg;
    logic [WORD_AW-1:0] clr_idx_reg;

    // ------------------------------------------------------------------
    // Stage 1: store data returns, modify and write back
    // ------------------------------------------------------------------
    logic               s1_valid_reg;
    logic               s1_set_reg;
    logic               s1_read_reg;
    logic [WORD_AW-1:0] s1_idx_reg;
    logic [BIT_W-1:0]   s1_bit_reg;
    logic [2:0]         s1_status_reg;
    logic [16:0]        s1_bytes_reg;

    logic                 fwd_valid_reg;
    logic [WORD_AW-1:0]   fwd_idx_reg;
    logic [WORD_BITS-1:0] fwd_data_reg;

    logic [WORD_BITS-1:0] store_mem [STORE_WORDS];
    logic [WORD_BITS-1:0] mem_q_reg;
    logic [WORD_AW-1:0]   rd_addr;

    logic [WORD_BITS-1:0] s1_word;
    logic [WORD_BITS-1:0] s1_wdata;
    logic                 s1_wr;

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    logic [2:0]           q_status [QD];
    logic [16:0]          q_bytes  [QD];
    logic [WORD_BITS-1:0] q_word   [QD];
    logic [1:0]           q_wr_reg, q_rd_reg, q_cnt_reg;

    logic acc, pop;
    logic [2:0] occupancy;

    // Character classes and the digit accumulators (only ever used on
    // the first pass, so they come straight from the registers).
    logic             is_digit, is_bit, ws_qf, ws_l;
    logic [3:0]       digit;
    logic [26:0]      count_prod, addr_prod;
    logic [NUM_W-1:0] count_acc, addr_acc;
    logic             done, again;

    assign digit    = s_text_char[3:0] - CH_0[3:0];
    assign is_digit = (s_text_char >= CH_0) && (s_text_char <= CH_9);
    assign is_bit   = (s_text_char == CH_0) || (s_text_char == CH_1);
    assign ws_qf    = (s_text_char == CH_SPACE) ||
                      ((s_text_char >= CH_TAB) && (s_text_char <= CH_CR));
    assign ws_l     = (s_text_char == CH_SPACE) || (s_text_char == CH_TAB) ||
                      (s_text_char == CH_CR) || (s_text_char == CH_LF);

    assign count_prod = {4'b0, count_reg} * 27'd10 + {23'b0, digit};
    assign addr_prod  = {4'b0, addr_reg} * 27'd10 + {23'b0, digit};
    assign count_acc  = (count_prod > {4'b0, NUM_SAT}) ? NUM_SAT : count_prod[NUM_W-1:0];
    assign addr_acc   = (addr_prod > {4'b0, NUM_SAT}) ? NUM_SAT : addr_prod[NUM_W-1:0];

    // Close the count digits: check zero, alignment, store size.
    function automatic logic [2:0] count_check(input logic [NUM_W-1:0] cnt);
        logic [2:0] res;
        res = ST_OK;
        if (cnt == '0) begin
            res = ST_QF_BAD;
        end else if (cnt[ALIGN_W-1:0] != '0) begin
            res = ST_UNALIGNED;
        end else if (cnt > NUM_W'(MAX_FUSES)) begin
            res = ST_TOO_BIG;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Next parser state. A text character may fall through up to four
    // phases; each pass reuses the same character.
    // ------------------------------------------------------------------
    always_comb begin
        phase_next  = phase_reg;
        last_q_next = last_q_reg;
        seen_next   = seen_reg;
        count_next  = count_reg;
        addr_next   = addr_reg;
        err_next    = err_reg;
        set_en      = 1'b0;
        set_addr    = addr_reg;
        done        = 1'b0;
        again       = 1'b0;
        case (cmd_t'(s_command))
            CMD_TEXT: begin
                for (int p = 0; p < 4; p++) begin
                    if (!done) begin
                        again = 1'b0;
                        if (err_next != ST_OK) begin
                            done = 1'b1;
                        end else begin
                            case (phase_next)
                                PH_SEEK: begin
                                    if ((s_text_char == CH_F) && last_q_next) begin
                                        phase_next = PH_QF_WS;
                                    end
                                    last_q_next = (s_text_char == CH_Q);
                                end
                                PH_QF_WS: begin
                                    if (is_digit) begin
                                        count_next = {19'b0, digit};
                                        phase_next = PH_QF_NUM;
                                    end else if (!ws_qf) begin
                                        err_next = ST_QF_BAD;
                                    end
                                end
                                PH_QF_NUM: begin
                                    if (is_digit) begin
                                        count_next = count_acc;
                                    end else begin
                                        err_next   = count_check(count_next);
                                        seen_next  = 1'b1;
                                        phase_next = PH_BODY;
                                        again      = 1'b1;
                                    end
                                end
                                PH_BODY: begin
                                    if (s_text_char == CH_L) begin
                                        phase_next = PH_L_START;
                                    end
                                end
                                PH_L_START: begin
                                    if (is_digit) begin
                                        addr_next  = {19'b0, digit};
                                        phase_next = PH_L_NUM;
                                    end else begin
                                        phase_next = PH_BODY;
                                        again      = 1'b1;
                                    end
                                end
                                PH_L_NUM: begin
                                    if (is_digit) begin
                                        addr_next = addr_acc;
                                    end else begin
                                        phase_next = PH_L_WS;
                                        again      = 1'b1;
                                    end
                                end
                                PH_L_WS: begin
                                    if (!ws_l) begin
                                        phase_next = is_bit ? PH_L_BITS : PH_BODY;
                                        again      = 1'b1;
                                    end
                                end
                                PH_L_BITS: begin
                                    if (is_bit) begin
                                        if (addr_next >= count_next) begin
                                            err_next = ST_ADDR_OOR;
                                        end else begin
                                            set_en   = (s_text_char == CH_1);
                                            set_addr = addr_next;
                                            if (addr_next < NUM_SAT) begin
                                                addr_next = addr_next + 1'b1;
                                            end
                                        end
                                    end else begin
                                        phase_next = PH_BODY;
                                        again      = 1'b1;
                                    end
                                end
                                default: begin
                                    phase_next = PH_SEEK;
                                end
                            endcase
                            if (!again) begin
                                done = 1'b1;
                            end
                        end
                    end
                end
            end
            CMD_END: begin
                if (err_reg == ST_OK) begin
                    if (phase_reg == PH_QF_NUM) begin
                        err_next   = count_check(count_reg);
                        seen_next  = 1'b1;
                        phase_next = PH_BODY;
                    end else if ((phase_reg == PH_SEEK) || (phase_reg == PH_QF_WS)) begin
                        err_next = ST_QF_BAD;
                    end
                end
            end
            default: begin
                // read and unused commands leave the parser alone
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: accept when not clearing and the queue plus stage 1 leave a free slot
    // ------------------------------------------------------------------
    assign occupancy = {1'b0, q_cnt_reg} + {2'b0, s1_valid_reg};
    assign s_ready   = !clearing_reg && (occupancy < 3'(QD));
    assign acc       = s_valid && s_ready;
    assign pop       = m_valid && m_ready;

    // Store read address: for a fuse bit write, the word from address bits above the bit offset; else the fetch index.
    assign rd_addr = set_en ? set_addr[BIT_W+WORD_AW-1:BIT_W] : s_word_index;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SEEK;
            last_q_reg <= 1'b0;
            seen_reg   <= 1'b0;
            count_reg  <= '0;
            addr_reg   <= '0;
            err_reg    <= ST_OK;
        end else if (acc) begin
            phase_reg  <= phase_next;
            last_q_reg <= last_q_next;
            seen_reg   <= seen_next;
            count_reg  <= count_next;
            addr_reg   <= addr_next;
            err_reg    <= err_next;
        end
    end

    // Stage 1 control and captured result fields
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_set_reg   <= 1'b0;
            s1_read_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= acc;
            s1_set_reg   <= acc && set_en;
            s1_read_reg  <= acc && (cmd_t'(s_command) == CMD_FETCH);
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            s1_idx_reg    <= rd_addr;
            s1_bit_reg    <= set_addr[BIT_W-1:0];
            s1_status_reg <= err_next;
            s1_bytes_reg  <= (seen_next && (err_next == ST_OK)) ? count_next[19:3] : '0;
        end
    end

    // ------------------------------------------------------------------
    // Fuse store: one read port, one write port shared with clearing
    // ------------------------------------------------------------------
    assign s1_word  = (fwd_valid_reg && (fwd_idx_reg == s1_idx_reg)) ? fwd_data_reg
                                                                      : mem_q_reg;
    assign s1_wdata = s1_word | (WORD_BITS'(1) << s1_bit_reg);
    assign s1_wr    = s1_valid_reg && s1_set_reg;

    always_ff @(posedge aclk) begin
        mem_q_reg <= store_mem[rd_addr];
        if (clearing_reg) begin
            store_mem[clr_idx_reg] <= '0;
        end else if (s1_wr) begin
            store_mem[s1_idx_reg] <= s1_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            fwd_valid_reg <= 1'b0;
        end else begin
            if (clearing_reg) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == {WORD_AW{1'b1}}) begin
                    clearing_reg <= 1'b0;
                end
            end
            fwd_valid_reg <= s1_wr;
        end
    end

    // Hold the last written word for an item that read the store before that write
    always_ff @(posedge aclk) begin
        if (s1_wr) begin
            fwd_idx_reg  <= s1_idx_reg;
            fwd_data_reg <= s1_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Output queue: push every stage 1 item, drop on result accept
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            q_status[q_wr_reg] <= s1_status_reg;
            q_bytes[q_wr_reg]  <= s1_bytes_reg;
            q_word[q_wr_reg]   <= s1_read_reg ? s1_word : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end else begin
            if (s1_valid_reg) begin
                q_wr_reg <= (q_wr_reg == 2'(QD - 1)) ? '0 : q_wr_reg + 1'b1;
            end
            if (pop) begin
                q_rd_reg <= (q_rd_reg == 2'(QD - 1)) ? '0 : q_rd_reg + 1'b1;
            end
            q_cnt_reg <= q_cnt_reg + {1'b0, s1_valid_reg} - {1'b0, pop};
        end
    end

    assign m_valid       = (q_cnt_reg != '0);
    assign m_status      = q_status[q_rd_reg];
    assign m_image_bytes = q_bytes[q_rd_reg];
    assign m_fuse_word   = q_word[q_rd_reg];

endmodule

// ===== hdl/jfmp_checker.sv =====
// ----------------------------------------------------------------------------
// jfmp_checker
// Port-level checks of the fuse map parser: result handshake, status range,
// sticky errors and image length consistency.
// ----------------------------------------------------------------------------
module jfmp_checker
    import jfmp_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [2:0]           m_status,
    input logic [16:0]          m_image_bytes,
    input logic [WORD_BITS-1:0] m_fuse_word
);

    logic       seen_reg;
    logic [2:0] last_status_reg;

    // Track the status of the last delivered item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg        <= 1'b0;
            last_status_reg <= ST_OK;
        end else if (m_valid && m_ready) begin
            seen_reg        <= 1'b1;
            last_status_reg <= m_status;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_fuse_word))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_OK) || (m_status == ST_QF_BAD) ||
                    (m_status == ST_UNALIGNED) || (m_status == ST_ADDR_OOR) ||
                    (m_status == ST_TOO_BIG))
        else $error("status code out of range");

    a_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && seen_reg && (last_status_reg != ST_OK) |-> m_status == last_status_reg)
        else $error("error status not sticky");

    a_len_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> m_image_bytes == '0)
        else $error("image length reported with an error");

    a_len_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !(s_valid && !s_ready && 1'b0) |-> m_image_bytes[3:0] == 4'd0)
        else $error("image length not a multiple of 16 bytes");

endmodule

bind jedec_fuse_map_parser_unit jfmp_checker u_jfmp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_image_bytes (m_image_bytes),
    .m_fuse_word   (m_fuse_word)
);

// ===== test/jedec_fuse_map_parser_unit_test.sv =====
// ----------------------------------------------------------------------------
// jedec_fuse_map_parser_unit_test
// Streams a fuse file through the parser one item at a time. Each accepted
// item updates a software copy of the parser and its fuse store, and each
// result item is checked field by field against that copy. Random idling sits
// on both channels.
// ----------------------------------------------------------------------------
module jedec_fuse_map_parser_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import jfmp_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_TICKS = 10;
    localparam int CYCLE_LIMIT = 600000;  // clearing pass plus a slow run, many times over
    localparam int TAIL_TICKS  = 10;      // result path is two stages deep
    localparam int RANDOM_ITEMS = 2000;

    // Characters the package does not name.
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;

    typedef struct packed {
        logic [2:0]           status;
        logic [16:0]          image_bytes;
        logic [WORD_BITS-1:0] fuse_word;
    } fuse_result_t;

    // Parser copy: phase, count, address, sticky status and the fuse store.
    class fuse_map_scoreboard;
        phase_t               phase;
        bit                   saw_q;
        bit                   count_done;
        int unsigned          fuse_count;
        int unsigned          fuse_addr;
        logic [2:0]           err;
        bit [WORD_BITS-1:0]   fuses [STORE_WORDS];
        fuse_result_t         pending_results [$];
        int                   failures;

        function new();
            phase      = PH_SEEK;
            saw_q      = 1'b0;
            count_done = 1'b0;
            fuse_count = 0;
            fuse_addr  = 0;
            err        = ST_OK;
            failures   = 0;
            foreach (fuses[i]) fuses[i] = '0;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_0 && c <= CH_9;
        endfunction

        function int unsigned grow(int unsigned acc, logic [7:0] c);
            int unsigned v;
            v = acc * 10 + (c - CH_0);
            return (v > NUM_SAT) ? NUM_SAT : v;
        endfunction

        function void close_count();
            if (fuse_count == 0) err = ST_QF_BAD;
            else if (fuse_count % (1 << ALIGN_W) != 0) err = ST_UNALIGNED;
            else if (fuse_count > MAX_FUSES) err = ST_TOO_BIG;
            count_done = 1'b1;
            phase      = PH_BODY;
        endfunction

        // A character that ends one phase is looked at again by the next one.
        function void parse_char(logic [7:0] c);
            bit again;
            for (int pass = 0; pass < 4; pass++) begin
                again = 1'b0;
                if (err != ST_OK) return;
                case (phase)
                    PH_SEEK: begin
                        if (c == CH_F && saw_q) phase = PH_QF_WS;
                        saw_q = (c == CH_Q);
                    end
                    PH_QF_WS: begin
                        if (is_digit(c)) begin
                            fuse_count = c - CH_0;
                            phase      = PH_QF_NUM;
                        end else if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
                            err = ST_QF_BAD;
                        end
                    end
                    PH_QF_NUM: begin
                        if (is_digit(c)) fuse_count = grow(fuse_count, c);
                        else begin
                            close_count();
                            again = 1'b1;
                        end
                    end
                    PH_BODY: begin
                        if (c == CH_L) phase = PH_L_START;
                    end
                    PH_L_START: begin
                        if (is_digit(c)) begin
                            fuse_addr = c - CH_0;
                            phase     = PH_L_NUM;
                        end else begin
                            phase = PH_BODY;
                            again = 1'b1;
                        end
                    end
                    PH_L_NUM: begin
                        if (is_digit(c)) fuse_addr = grow(fuse_addr, c);
                        else begin
                            phase = PH_L_WS;
                            again = 1'b1;
                        end
                    end
                    PH_L_WS: begin
                        if (!(c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF)) begin
                            phase = (c == CH_0 || c == CH_1) ? PH_L_BITS : PH_BODY;
                            again = 1'b1;
                        end
                    end
                    default: begin
                        if (c == CH_0 || c == CH_1) begin
                            if (fuse_addr >= fuse_count) err = ST_ADDR_OOR;
                            else begin
                                if (c == CH_1 && (fuse_addr >> BIT_W) < STORE_WORDS)
                                    fuses[fuse_addr >> BIT_W][fuse_addr % WORD_BITS] = 1'b1;
                                if (fuse_addr < NUM_SAT) fuse_addr++;
                            end
                        end else begin
                            phase = PH_BODY;
                            again = 1'b1;
                        end
                    end
                endcase
                if (!again) return;
            end
        endfunction

        function void take_item(logic [1:0] cmd, logic [7:0] ch, logic [WORD_AW-1:0] idx);
            fuse_result_t r;
            r.fuse_word = '0;
            case (cmd)
                CMD_TEXT: parse_char(ch);
                CMD_END: begin
                    if (err == ST_OK) begin
                        if (phase == PH_QF_NUM) close_count();
                        else if (phase == PH_SEEK || phase == PH_QF_WS) err = ST_QF_BAD;
                    end
                end
                CMD_FETCH: if (idx < STORE_WORDS) r.fuse_word = fuses[idx];
                default: ;
            endcase
            r.status      = err;
            r.image_bytes = (count_done && err == ST_OK) ? 17'(fuse_count / 8) : '0;
            pending_results.push_back(r);
        endfunction

        function void flag(string what, logic [63:0] want, logic [63:0] got);
            failures++;
            if (failures <= 10)
                $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
        endfunction

        function void check_result(logic [2:0] status, logic [16:0] image_bytes,
                                   logic [WORD_BITS-1:0] fuse_word);
            fuse_result_t want;
            if (pending_results.size() == 0) begin
                flag("result with nothing pending, status", 0, status);
                return;
            end
            want = pending_results.pop_front();
            if (want.status !== status) flag("status", want.status, status);
            if (want.image_bytes !== image_bytes)
                flag("image_bytes", want.image_bytes, image_bytes);
            if (want.fuse_word !== fuse_word) flag("fuse_word", want.fuse_word, fuse_word);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_command = CMD_NONE;
    logic [7:0]           s_text_char = '0;
    logic [WORD_AW-1:0]   s_word_index = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [2:0]           m_status;
    logic [16:0]          m_image_bytes;
    logic [WORD_BITS-1:0] m_fuse_word;

    fuse_map_scoreboard sb = new();

    bit          idle_on = 1'b0;   // enables random gaps and stalls
    int          sent_items = 0;
    int          stall_left = 0;
    int          cycles = 0;
    int unsigned count_val;
    int unsigned last_word = 0;    // word touched by the latest record, for reads

    jedec_fuse_map_parser_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_text_char   (s_text_char),
        .s_word_index  (s_word_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_image_bytes (m_image_bytes),
        .m_fuse_word   (m_fuse_word)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Abort the run if the block hangs, including during the clearing pass.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("jedec_fuse_map_parser_unit verification failed");
            $finish;
        end
    end

    // Result side: check every accepted item, then pick next cycle's ready.
    // Stalls come in bursts.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_status, m_image_bytes, m_fuse_word);
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Offer one item and hold it until accepted. Valid stays high into the next
    // item unless a gap is drawn, so valid is never dropped and raised in one step.
    task automatic send_item(logic [1:0] cmd, logic [7:0] ch, logic [WORD_AW-1:0] idx);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_text_char  <= ch;
        s_word_index <= idx;
        do @(posedge aclk); while (!s_ready);
        sb.take_item(cmd, ch, idx);
        sent_items++;
    endtask

    // Text characters carry a random word index; it is ignored for them.
    task automatic send_char(logic [7:0] ch);
        send_item(CMD_TEXT, ch, WORD_AW'($urandom_range(0, STORE_WORDS - 1)));
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    task automatic send_cmd(logic [1:0] cmd);
        send_item(cmd, 8'($urandom_range(0, 255)), WORD_AW'($urandom_range(0, STORE_WORDS - 1)));
    endtask

    task automatic read_word(logic [WORD_AW-1:0] idx);
        send_item(CMD_FETCH, 8'($urandom_range(0, 255)), idx);
    endtask

    task automatic send_sep();
        case ($urandom_range(0, 3))
            0: send_char(CH_SPACE);
            1: send_char(CH_TAB);
            2: send_char(CH_CR);
            default: send_char(CH_LF);
        endcase
    endtask

    // Well-formed record: address below the count, separators, bits that stay
    // inside the count, then a star and an optional line break.
    task automatic send_record();
        int unsigned addr;
        int unsigned nbits;
        addr  = $urandom_range(0, count_val - 1);
        nbits = $urandom_range(1, 48);
        if (nbits > count_val - addr) nbits = count_val - addr;
        last_word = addr >> BIT_W;
        send_char(CH_L);
        if ($urandom_range(0, 3) == 0) send_char(CH_0);  // leading zero
        send_text($sformatf("%0d", addr));
        repeat ($urandom_range(1, 3)) send_sep();
        repeat (nbits) send_char($urandom_range(0, 1) ? CH_1 : CH_0);
        send_char(CH_STAR);
        if ($urandom_range(0, 1)) begin
            send_char(CH_CR);
            send_char(CH_LF);
        end
    endtask

    // Records that must leave the store alone: signed, bare, oversized, or cut by
    // a character that is not a separator after the address.
    task automatic send_broken_record();
        case ($urandom_range(0, 3))
            0: begin
                send_char(CH_L);
                send_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                send_text($sformatf("%0d 1*", $urandom_range(0, count_val - 1)));
            end
            1: begin
                send_text($sformatf("L%0d", $urandom_range(0, count_val - 1)));
                send_sep();
                send_char(CH_STAR);
            end
            2: send_text("L99999999 *");
            default: begin
                send_text($sformatf("L%0d", $urandom_range(0, count_val - 1)));
                send_char($urandom_range(0, 1) ? CH_VT : CH_FF);
                send_text("1*");
            end
        endcase
    endtask

    // Body noise: anything but the record start.
    task automatic send_noise();
        logic [7:0] c;
        repeat ($urandom_range(1, 4)) begin
            do c = $urandom_range(0, 255); while (c == CH_L);
            send_char(c);
        end
    endtask

    // Drop valid and hold until every expected result is back.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        int next_switch;
        bit paused;

        repeat (RESET_TICKS) @(posedge aclk);
        aresetn <= 1'b1;

        // Pick the fuse count: smallest, largest, or anything aligned between.
        case ($urandom_range(0, 3))
            0: count_val = 1 << ALIGN_W;
            1: count_val = MAX_FUSES;
            default: count_val = (1 << ALIGN_W) * $urandom_range(1, MAX_FUSES >> ALIGN_W);
        endcase

        // Directed: reads of the cleared store, the unused command, a record
        // ahead of the count (ignored), a broken and a good QF, every kind of
        // whitespace before the count.
        read_word('0);
        read_word('1);
        send_cmd(CMD_NONE);
        send_text("L5 1*");
        send_text("Q*FQQF");
        send_char(CH_SPACE);
        send_char(CH_TAB);
        send_char(CH_LF);
        send_char(CH_VT);
        send_char(CH_FF);
        send_char(CH_CR);
        send_text($sformatf("%0d", count_val));
        // Close the count either by end of text or by the record start itself.
        if ($urandom_range(0, 1)) send_cmd(CMD_END);
        send_text("L0 1*");
        send_text($sformatf("L%0d", count_val - 1));
        send_char(CH_CR);
        send_char(CH_LF);
        send_text("1*");
        read_word('0);
        read_word(WORD_AW'((count_val - 1) >> BIT_W));
        send_text("L+3 1*L-3 1*");
        send_text("L99999999 *");
        send_cmd(CMD_END);

        // Random: mostly good records with random content, some reads, commands,
        // noise and broken records. Idling switches on and off in stretches.
        idle_on     = 1'b1;
        next_switch = sent_items + 150;
        paused      = 1'b0;
        while (sent_items < RANDOM_ITEMS) begin
            if (sent_items >= next_switch) begin
                idle_on     = ($urandom_range(0, 3) != 0);
                next_switch = sent_items + $urandom_range(50, 250);
            end
            if (!paused && sent_items >= RANDOM_ITEMS / 2) begin
                drain();
                paused = 1'b1;
            end
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: send_record();
                12, 13: read_word($urandom_range(0, 1) ? WORD_AW'(last_word)
                                                       : WORD_AW'($urandom_range(0, STORE_WORDS - 1)));
                14: send_cmd($urandom_range(0, 1) ? CMD_END : CMD_NONE);
                15, 16: send_noise();
                default: send_broken_record();
            endcase
        end

        // Last part, no idling: a few more records, then an address at the count
        // to set the sticky range error, then items that must see it stay.
        idle_on = 1'b0;
        repeat (5) begin
            send_record();
            read_word(WORD_AW'(last_word));
        end
        send_text($sformatf("L%0d 1*", count_val));
        send_text("L0 1*");
        send_cmd(CMD_END);
        read_word('0);
        read_word(WORD_AW'($urandom_range(0, STORE_WORDS - 1)));

        drain();
        repeat (TAIL_TICKS) @(posedge aclk);
        if (sb.failures == 0) begin
            $display("jedec_fuse_map_parser_unit verification clean");
        end else begin
            $display("jedec_fuse_map_parser_unit verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/jfmp_pkg.sv
hdl/jedec_fuse_map_parser_unit.sv
hdl/jfmp_checker.sv
test/jedec_fuse_map_parser_unit_test.sv
